// File: src/dctd_pkg.sv
package dctd_pkg;

	localparam int COUNT_W = 11;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam int OUT_TW = ((COUNT_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_FILL,
		ST_IDLE,
		ST_CHECK,
		ST_SQ,
		ST_CMP,
		ST_DIV,
		ST_DSTART,
		ST_OUT
	} core_state_t;

	typedef enum logic [2:0] {
		SV_CLEAR,
		SV_READ,
		SV_CHECK,
		SV_MARK,
		SV_DONE
	} sieve_state_t;

	typedef struct packed {
		logic wr_en;
		logic done;
	} tbl_ctl_t;

endpackage

// File: src/dctd_ram.sv
module dctd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// File: src/dctd_div.sv
module dctd_div #(
	parameter int NUM_W = 31,
	parameter int DEN_W = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient,
	output logic [DEN_W-1:0] remainder
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1)) && !start;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0) && (cnt_q <= CNT_W'(NUM_W)))
		else $error("divider step count out of range");

endmodule

// File: src/dctd_sieve.sv
module dctd_sieve #(
	parameter int PRIME_LIMIT = 65536,
	parameter int PRIME_COUNT = 6542
) (
	input  logic                               clk,
	input  logic                               arst_n,
	output dctd_pkg::tbl_ctl_t                 ctl,
	output logic [$clog2(PRIME_COUNT)-1:0]     wr_addr,
	output logic [$clog2(PRIME_LIMIT)-1:0]     wr_data,
	output logic [$clog2(PRIME_COUNT+1)-1:0]   fill
);

	localparam int NW = $clog2(PRIME_LIMIT);
	localparam int AW = $clog2(PRIME_COUNT);
	localparam int FW = $clog2(PRIME_COUNT + 1);
	localparam logic [NW-1:0] LAST = NW'(PRIME_LIMIT - 1);

	dctd_pkg::sieve_state_t state_q, state_d;

	logic [NW-1:0] i_q;
	logic [NW:0]   j_q;
	logic [FW-1:0] fill_q;
	logic          cmp_we;
	logic [NW-1:0] cmp_waddr;
	logic [0:0]    cmp_wdata;
	logic [0:0]    cmp_rdata;
	logic          is_prime;
	logic          j_end;

	dctd_ram #(
		.WIDTH (1),
		.DEPTH (PRIME_LIMIT)
	) u_composite (
		.clk     (clk),
		.wr_en   (cmp_we),
		.wr_addr (cmp_waddr),
		.wr_data (cmp_wdata),
		.rd_addr (i_q),
		.rd_data (cmp_rdata)
	);

	assign is_prime = !cmp_rdata[0];
	assign j_end    = j_q >= (NW+1)'(PRIME_LIMIT);

	always_comb begin
		state_d = state_q;
		case (state_q)
			dctd_pkg::SV_CLEAR: begin
				if (i_q == LAST) begin
					state_d = dctd_pkg::SV_READ;
				end
			end
			dctd_pkg::SV_READ: begin
				state_d = dctd_pkg::SV_CHECK;
			end
			dctd_pkg::SV_CHECK: begin
				if (is_prime) begin
					if (fill_q == FW'(PRIME_COUNT - 1)) begin
						state_d = dctd_pkg::SV_DONE;
					end else begin
						state_d = dctd_pkg::SV_MARK;
					end
				end else if (i_q == LAST) begin
					state_d = dctd_pkg::SV_DONE;
				end else begin
					state_d = dctd_pkg::SV_READ;
				end
			end
			dctd_pkg::SV_MARK: begin
				if (j_end) begin
					state_d = (i_q == LAST) ? dctd_pkg::SV_DONE : dctd_pkg::SV_READ;
				end
			end
			dctd_pkg::SV_DONE: begin
				state_d = dctd_pkg::SV_DONE;
			end
			default: begin
				state_d = dctd_pkg::SV_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmp_we    = 1'b0;
		cmp_waddr = i_q;
		cmp_wdata = 1'b0;
		ctl       = '0;
		case (state_q)
			dctd_pkg::SV_CLEAR: begin
				cmp_we = 1'b1;
			end
			dctd_pkg::SV_CHECK: begin
				ctl.wr_en = is_prime;
			end
			dctd_pkg::SV_MARK: begin
				cmp_we    = !j_end;
				cmp_waddr = j_q[NW-1:0];
				cmp_wdata = 1'b1;
			end
			dctd_pkg::SV_DONE: begin
				ctl.done = 1'b1;
			end
			default: begin
				cmp_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dctd_pkg::SV_CLEAR;
			i_q     <= '0;
			j_q     <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				dctd_pkg::SV_CLEAR: begin
					i_q <= (i_q == LAST) ? NW'(2) : i_q + NW'(1);
				end
				dctd_pkg::SV_CHECK: begin
					if (is_prime) begin
						fill_q <= fill_q + FW'(1);
						j_q    <= {i_q, 1'b0};
					end else if (i_q != LAST) begin
						i_q <= i_q + NW'(1);
					end
				end
				dctd_pkg::SV_MARK: begin
					if (j_end) begin
						if (i_q != LAST) begin
							i_q <= i_q + NW'(1);
						end
					end else begin
						j_q <= j_q + (NW+1)'(i_q);
					end
				end
				default: begin
					j_q <= j_q;
				end
			endcase
		end
	end

	assign wr_addr = fill_q[AW-1:0];
	assign wr_data = i_q;
	assign fill    = fill_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(PRIME_COUNT))
		else $error("prime table overfilled");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_en |-> (fill_q < FW'(PRIME_COUNT)) && (i_q >= NW'(2)))
		else $error("prime table write out of range");

	a_mark_above: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dctd_pkg::SV_MARK) |-> (j_q > (NW+1)'(i_q)))
		else $error("sieve marks at or below its own prime");

endmodule

// File: src/divisor_count_trial_division_core.sv
// Channel  Dir  Signals                    Payload
// s_*      in   s_tvalid s_tready s_tdata  value (VALUE_BITS)
// m_*      out  m_tvalid m_tready m_tdata  divisor_count (11)
//
// One item at a time. Per item, for each table prime tried, (e + 1) divisions run on
// the serial divider with a restart before each repeat, where e is that prime's exponent.
// After reset the sieve clears its PRIME_LIMIT-entry composite memory, then fills the
// prime table; s_tready stays low meanwhile.
// A finished count waits in the output register; the next transfer is taken meanwhile.
module divisor_count_trial_division_core #(
	parameter int PRIME_LIMIT = 65536,
	parameter int PRIME_COUNT = 6542,
	parameter int VALUE_BITS  = 31
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]      s_tdata,  // value
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [dctd_pkg::OUT_TW-1:0]          m_tdata   // divisor_count
);

	localparam int PW = $clog2(PRIME_LIMIT);
	localparam int AW = $clog2(PRIME_COUNT);
	localparam int FW = $clog2(PRIME_COUNT + 1);
	localparam int EW = $clog2(VALUE_BITS + 2);
	localparam int CW = (2 * PW > VALUE_BITS) ? 2 * PW : VALUE_BITS;
	localparam int MW = dctd_pkg::COUNT_W + EW;
	localparam int KW = dctd_pkg::COUNT_W;

	dctd_pkg::core_state_t state_q, state_d;
	dctd_pkg::tbl_ctl_t    tbl_ctl;

	logic [AW-1:0]         tbl_wr_addr;
	logic [PW-1:0]         tbl_wr_data;
	logic [PW-1:0]         tbl_rd_data;
	logic [FW-1:0]         fill;
	logic [VALUE_BITS-1:0] rest_q;
	logic [KW-1:0]         count_q;
	logic [FW-1:0]         k_q;
	logic [EW-1:0]         e1_q;
	logic [PW-1:0]         p_q;
	logic [2*PW-1:0]       sq_q;
	logic                  m_tvalid_q;
	logic [KW-1:0]         m_count_q;
	logic                  div_start;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quot;
	logic [PW-1:0]         div_rem;
	logic                  rest_small;
	logic                  k_end;
	logic                  stop_cmp;
	logic [MW-1:0]         prod;
	logic [KW-1:0]         count_mul;
	logic [KW:0]           dbl;
	logic [KW-1:0]         count_fin;
	logic                  out_free;

	dctd_sieve #(
		.PRIME_LIMIT (PRIME_LIMIT),
		.PRIME_COUNT (PRIME_COUNT)
	) u_sieve (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data),
		.fill    (fill)
	);

	dctd_ram #(
		.WIDTH (PW),
		.DEPTH (PRIME_COUNT)
	) u_primes (
		.clk     (clk),
		.wr_en   (tbl_ctl.wr_en),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data),
		.rd_addr (k_q[AW-1:0]),
		.rd_data (tbl_rd_data)
	);

	dctd_div #(
		.NUM_W (VALUE_BITS),
		.DEN_W (PW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (rest_q),
		.divisor   (p_q),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	assign rest_small = rest_q[VALUE_BITS-1:1] == '0;
	assign k_end      = k_q >= fill;
	assign stop_cmp   = (p_q < PW'(2)) || (CW'(sq_q) > CW'(rest_q));
	assign prod       = MW'(count_q) * MW'(e1_q);
	assign count_mul  = (prod > MW'(dctd_pkg::COUNT_MAX)) ? dctd_pkg::COUNT_MAX : prod[KW-1:0];
	assign dbl        = {count_q, 1'b0};
	assign out_free   = !m_tvalid_q || m_tready;

	always_comb begin
		if (rest_q == VALUE_BITS'(1)) begin
			count_fin = count_q;
		end else if (dbl[KW]) begin
			count_fin = dctd_pkg::COUNT_MAX;
		end else begin
			count_fin = dbl[KW-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			dctd_pkg::ST_FILL: begin
				if (tbl_ctl.done) begin
					state_d = dctd_pkg::ST_IDLE;
				end
			end
			dctd_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = dctd_pkg::ST_CHECK;
				end
			end
			dctd_pkg::ST_CHECK: begin
				state_d = (rest_small || k_end) ? dctd_pkg::ST_OUT : dctd_pkg::ST_SQ;
			end
			dctd_pkg::ST_SQ: begin
				state_d = dctd_pkg::ST_CMP;
			end
			dctd_pkg::ST_CMP: begin
				state_d = stop_cmp ? dctd_pkg::ST_OUT : dctd_pkg::ST_DIV;
			end
			dctd_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = (div_rem == '0) ? dctd_pkg::ST_DSTART : dctd_pkg::ST_CHECK;
				end
			end
			dctd_pkg::ST_DSTART: begin
				state_d = dctd_pkg::ST_DIV;
			end
			dctd_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = dctd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dctd_pkg::ST_FILL;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			dctd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
			end
			dctd_pkg::ST_CMP: begin
				div_start = !stop_cmp;
			end
			dctd_pkg::ST_DSTART: begin
				div_start = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dctd_pkg::ST_FILL;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dctd_pkg::ST_IDLE && s_tvalid) begin
				k_q <= '0;
			end else if (state_q == dctd_pkg::ST_DIV && div_done && div_rem != '0) begin
				k_q <= k_q + FW'(1);
			end
			if (state_q == dctd_pkg::ST_OUT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dctd_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					rest_q  <= s_tdata[VALUE_BITS-1:0];
					count_q <= KW'(1);
					e1_q    <= EW'(1);
				end
			end
			dctd_pkg::ST_SQ: begin
				p_q  <= tbl_rd_data;
				sq_q <= (2*PW)'(tbl_rd_data) * (2*PW)'(tbl_rd_data);
			end
			dctd_pkg::ST_DIV: begin
				if (div_done) begin
					if (div_rem == '0) begin
						rest_q <= div_quot;
						e1_q   <= e1_q + EW'(1);
					end else begin
						count_q <= count_mul;
						e1_q    <= EW'(1);
					end
				end
			end
			dctd_pkg::ST_OUT: begin
				if (out_free) begin
					m_count_q <= count_fin;
				end
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(dctd_pkg::OUT_TW - KW){1'b0}}, m_count_q};

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != dctd_pkg::ST_FILL) |-> (k_q <= fill))
		else $error("prime index beyond table fill");

	a_div_prime: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dctd_pkg::ST_DIV) |-> (p_q >= PW'(2)))
		else $error("division by a value below two");

	a_rest_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dctd_pkg::ST_DIV && $past(state_q) == dctd_pkg::ST_DIV)
		|-> (rest_q <= $past(rest_q)))
		else $error("cofactor grew during division");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (m_count_q != '0))
		else $error("zero divisor count presented");

endmodule

// File: tb/dctd_count_checker.sv
module dctd_count_checker #(
	parameter int PRIME_LIMIT = 65536,
	parameter int PRIME_COUNT = 6542,
	parameter int VALUE_BITS  = 31
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	input  logic                                 s_tready,
	input  logic [((VALUE_BITS+7)/8)*8-1:0]      s_tdata,  // value
	input  logic                                 m_tvalid,
	input  logic                                 m_tready,
	input  logic [dctd_pkg::OUT_TW-1:0]          m_tdata,  // divisor_count
	output int                                   fail_count,
	output int                                   waiting,
	output int                                   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COUNT_W = dctd_pkg::COUNT_W;

	typedef struct {
		logic [VALUE_BITS-1:0] value;
		logic [COUNT_W-1:0]    count;
	} pending_count_t;

	pending_count_t pending_counts[$];
	int unsigned    prime_list[PRIME_COUNT];
	int unsigned    prime_fill;

	initial begin
		bit is_composite[PRIME_LIMIT];
		prime_fill = 0;
		for (int i = 0; i < PRIME_LIMIT; i++)
			is_composite[i] = 1'b0;
		for (int i = 2; i < PRIME_LIMIT; i++) begin
			if (!is_composite[i]) begin
				if (prime_fill < PRIME_COUNT) begin
					prime_list[prime_fill] = i;
					prime_fill++;
				end
				for (int j = i + i; j < PRIME_LIMIT; j += i)
					is_composite[j] = 1'b1;
			end
		end
	end

	function automatic logic [COUNT_W-1:0] count_divisors(input logic [VALUE_BITS-1:0] v);
		longint unsigned rest;
		longint unsigned p;
		longint unsigned e1;
		longint unsigned total;
		int unsigned     k;
		rest  = v;
		total = 1;
		k     = 0;
		while (rest > 1 && k < prime_fill) begin
			p  = prime_list[k];
			e1 = 1;
			if (p < 2 || p * p > rest)
				break;
			while (rest % p == 0) begin
				e1++;
				rest = rest / p;
			end
			total = total * e1;
			if (total > dctd_pkg::COUNT_MAX)
				total = dctd_pkg::COUNT_MAX;
			k++;
		end
		if (rest != 1) begin
			total = total * 2;
			if (total > dctd_pkg::COUNT_MAX)
				total = dctd_pkg::COUNT_MAX;
		end
		return total[COUNT_W-1:0];
	endfunction

	initial begin
		fail_count = 0;
		waiting    = 0;
		checked    = 0;
	end

	always @(posedge clk) begin
		pending_count_t head;
		pending_count_t entry;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_counts.size() == 0) begin
					$display("%0t: unexpected divisor count transfer: expected none, got %0d",
						$time, m_tdata[COUNT_W-1:0]);
					fail_count++;
				end else begin
					head = pending_counts.pop_front();
					checked++;
					if (m_tdata[COUNT_W-1:0] !== head.count) begin
						$display("%0t: divisor_count mismatch for value %0d: expected %0d, got %0d",
							$time, head.value, head.count, m_tdata[COUNT_W-1:0]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				entry.value = s_tdata[VALUE_BITS-1:0];
				entry.count = count_divisors(entry.value);
				pending_counts.push_back(entry);
			end
			waiting = pending_counts.size();
		end
	end

endmodule

// File: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          VALUE_BITS  = 31;
	localparam int          S_TW        = ((VALUE_BITS + 7) / 8) * 8;
	localparam int          CYCLE_LIMIT = 8000000;
	localparam int          HOLD_CYCLES = 3000;
	localparam int          RANDOM_ITEMS = 100;
	localparam int          CALM_ITEMS  = 20;
	localparam longint unsigned VALUE_SPAN = 64'd1 << VALUE_BITS;

	logic                        clk      = 1'b0;
	logic                        arst_n   = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [S_TW-1:0]             s_tdata  = '0;  // value
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [dctd_pkg::OUT_TW-1:0] m_tdata;        // divisor_count

	int fail_count;
	int waiting;
	int checked;
	int sent        = 0;
	int cycle_count = 0;
	bit idle_on     = 1'b1;
	bit hold_req    = 1'b0;

	int unsigned small_primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
		53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

	logic [VALUE_BITS-1:0] directed_values[16] = '{
		31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd6,
		31'd1073741824,  // 2^30
		31'd2147483647,  // largest value, a prime
		31'd2095133040,  // 1600 divisors
		31'd1162261467,  // 3^19
		31'd63001,       // 251^2, prime squared equals the cofactor
		31'd65521,       // largest prime in the table
		31'd65537,       // prime above the table
		31'd2147483646,
		31'd1431655765,
		31'd715827882
	};

	divisor_count_trial_division_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	dctd_count_checker #(
		.VALUE_BITS(VALUE_BITS)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.fail_count(fail_count),
		.waiting   (waiting),
		.checked   (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// hold off the output once for a long stretch, otherwise stall in short random bursts while idle_on is set
	always begin
		@(negedge clk);
		if (hold_req) begin
			hold_req = 1'b0;
			m_tready <= 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_value(input logic [VALUE_BITS-1:0] v);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TW-VALUE_BITS){1'b0}}, v};
		do
			@(posedge clk);
		while (!s_tready);
		sent++;
		@(negedge clk);
	endtask

	// products of small primes, mostly times a modest cofactor so trial division stays short
	function automatic logic [VALUE_BITS-1:0] smooth_value();
		longint unsigned v;
		longint unsigned f;
		longint unsigned cofactor;
		v = 1;
		repeat ($urandom_range(0, 30)) begin
			f = small_primes[$urandom_range(0, $urandom_range(0, 24))];
			if (v * f < VALUE_SPAN)
				v = v * f;
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: cofactor = $urandom_range(1, 4095);
			6:                cofactor = $urandom_range(1, 1 << 20);
			default:          cofactor = 1;
		endcase
		if (v * cofactor < VALUE_SPAN)
			v = v * cofactor;
		return v[VALUE_BITS-1:0];
	endfunction

	initial begin
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_values[i])
			send_value(directed_values[i]);

		hold_req = 1'b1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				idle_on = 1'b0;
			if ($urandom_range(0, 9) == 0)
				send_value(VALUE_BITS'($urandom_range(0, 1 << 16)));
			else
				send_value(smooth_value());
		end
		s_tvalid <= 1'b0;

		while (waiting != 0)
			@(negedge clk);
		repeat (40) @(posedge clk);

		$display("Checked %0d divisor counts over %0d values: zero, one, primes up to 2^31-1,",
			checked, sent);
		$display("prime powers, a 1600-divisor value, smooth products and a %0d-cycle output hold.",
			HOLD_CYCLES);
		if (fail_count == 0 && waiting == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
